// ===== hw/rtl/fpba_pkg.sv =====
// Shared types, codes and defaults of the fit policy block allocator.
package fpba_pkg;

    localparam int DEF_NUM_BLOCKS = 16;
    localparam int DEF_SIZE_BITS  = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

    localparam logic [1:0] MODE_FIRST = 2'd0;
    localparam logic [1:0] MODE_BEST  = 2'd1;
    localparam logic [1:0] MODE_WORST = 2'd2;

    localparam logic [1:0] FIT_MODE_RST    = MODE_FIRST;
    localparam logic [4:0] BLOCK_COUNT_RST = 5'd16;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_REQ  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [3:0]  load_index;
        logic [31:0] size_value;
    } t_in_item;

    typedef struct packed {
        logic        granted;
        logic [3:0]  chosen_index;
        logic [31:0] size_left;
    } t_out_item;

    typedef struct packed {
        logic       start;
        logic       valid;
        logic [1:0] mode;
    } t_sel_ctl;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } t_state;

endpackage

// ===== hw/rtl/fpba_mem.sv =====
// Free size table: one write port, one registered read port.
module fpba_mem #(
    parameter int DEPTH = fpba_pkg::DEF_NUM_BLOCKS,
    parameter int WIDTH = fpba_pkg::DEF_SIZE_BITS,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/fpba_sel.sv =====
// Placement selection: folds one table entry per cycle into the running pick.
module fpba_sel #(
    parameter int IDX_W     = 4,
    parameter int SIZE_BITS = fpba_pkg::DEF_SIZE_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  fpba_pkg::t_sel_ctl   i_ctl,
    input  logic [SIZE_BITS-1:0] i_rdata,
    input  logic [IDX_W-1:0]     i_ridx,
    input  logic [SIZE_BITS-1:0] i_size,
    output logic                 o_found,
    output logic [IDX_W-1:0]     o_pick,
    output logic [SIZE_BITS-1:0] o_best
);

    logic                 r_found;
    logic [IDX_W-1:0]     r_pick;
    logic [SIZE_BITS-1:0] r_best;
    logic                 take;

    always_comb begin
        take = 1'b0;
        if (i_ctl.valid && (i_rdata >= i_size)) begin
            if (!r_found) begin
                take = 1'b1;
            end else begin
                case (i_ctl.mode)
                    fpba_pkg::MODE_BEST:  take = (i_rdata < r_best);
                    fpba_pkg::MODE_WORST: take = (i_rdata > r_best);
                    default:              take = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.start) begin
            r_found <= 1'b0;
        end else if (take) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_pick <= i_ridx;
            r_best <= i_rdata;
        end
    end

    assign o_found = r_found;
    assign o_pick  = r_pick;
    assign o_best  = r_best;

endmodule

// ===== hw/rtl/fit_policy_block_allocator_core.sv =====
// Top level of the fit policy block allocator: control, configuration, result register.
// A load leaves the block idle. A request scans the first used table entries, where used is
// block_count capped at NUM_BLOCKS: the free size table sits in a single-port-read memory,
// so the scan reads one entry per cycle, the selection unit folds each entry in as it
// returns, and the done state, once the result register is free, writes the reduced size
// back and loads the result register. The result register lets a new item in while the
// previous result still waits. After reset a clearing pass zeroes the table and no item is
// taken meanwhile; configuration writes are taken at any time, and block_count 0 refuses
// every request.
module fit_policy_block_allocator_core #(
    parameter int NUM_BLOCKS = fpba_pkg::DEF_NUM_BLOCKS,
    parameter int SIZE_BITS  = fpba_pkg::DEF_SIZE_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [fpba_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fpba_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  fpba_pkg::t_in_item                  i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output fpba_pkg::t_out_item                 o_out_data
);

    localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
    localparam int UW    = (CNT_W > 5) ? CNT_W : 5;

    fpba_pkg::t_state    r_state, n_state;
    logic [1:0]          r_fit_mode;
    logic [4:0]          r_block_count;
    logic [IDX_W-1:0]    r_clr_addr;
    logic [SIZE_BITS-1:0] r_size;
    logic [CNT_W-1:0]    r_used;
    logic [CNT_W-1:0]    r_addr;
    logic                r_rvalid;
    logic [IDX_W-1:0]    r_ridx;
    logic                r_out_valid;
    fpba_pkg::t_out_item r_out_data;

    logic                 in_fire, is_req, is_load, load_ok;
    logic [UW-1:0]        bc_ext, used_sat;
    logic [CNT_W-1:0]     used_calc;
    logic                 scan_issue, scan_last, clr_last, done_fire;
    logic                 mem_we, mem_re;
    logic [IDX_W-1:0]     mem_waddr;
    logic [SIZE_BITS-1:0] mem_wdata, mem_rdata;
    fpba_pkg::t_sel_ctl   sel_ctl;
    logic                 sel_found;
    logic [IDX_W-1:0]     sel_pick;
    logic [SIZE_BITS-1:0] sel_best, wb_val;

    assign o_cfg_ready = 1'b1;

    assign in_fire   = i_in_valid && o_in_ready;
    assign is_req    = in_fire && (i_in_data.op == fpba_pkg::OP_REQ);
    assign is_load   = in_fire && (i_in_data.op == fpba_pkg::OP_LOAD);
    assign load_ok   = (32'(i_in_data.load_index) < 32'(NUM_BLOCKS));
    assign bc_ext    = UW'(r_block_count);
    assign used_sat  = (bc_ext > UW'(NUM_BLOCKS)) ? UW'(NUM_BLOCKS) : bc_ext;
    assign used_calc = CNT_W'(used_sat);

    assign scan_issue = (r_state == fpba_pkg::ST_SCAN) && (r_addr < r_used);
    assign scan_last  = (r_state == fpba_pkg::ST_SCAN) && r_rvalid && (r_addr == r_used);
    assign clr_last   = (r_clr_addr == IDX_W'(NUM_BLOCKS - 1));
    assign done_fire  = (r_state == fpba_pkg::ST_DONE) && (!r_out_valid || i_out_ready);
    assign wb_val     = sel_best - r_size;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fpba_pkg::ST_CLEAR: if (clr_last) n_state = fpba_pkg::ST_IDLE;
            fpba_pkg::ST_IDLE: begin
                if (is_req) begin
                    n_state = (used_calc == '0) ? fpba_pkg::ST_DONE : fpba_pkg::ST_SCAN;
                end
            end
            fpba_pkg::ST_SCAN:  if (scan_last) n_state = fpba_pkg::ST_DONE;
            fpba_pkg::ST_DONE:  if (done_fire) n_state = fpba_pkg::ST_IDLE;
            default:            n_state = fpba_pkg::ST_CLEAR;
        endcase
    end

    // State outputs: memory ports and selection control
    always_comb begin
        o_in_ready    = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = r_clr_addr;
        mem_wdata     = '0;
        mem_re        = scan_issue;
        sel_ctl.start = is_req;
        sel_ctl.valid = r_rvalid && (r_state == fpba_pkg::ST_SCAN);
        sel_ctl.mode  = r_fit_mode;
        unique case (r_state)
            fpba_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
            end
            fpba_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                mem_we     = is_load && load_ok;
                mem_waddr  = IDX_W'(i_in_data.load_index);
                mem_wdata  = SIZE_BITS'(i_in_data.size_value);
            end
            fpba_pkg::ST_DONE: begin
                mem_we    = done_fire && sel_found;
                mem_waddr = sel_pick;
                mem_wdata = wb_val;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= fpba_pkg::ST_CLEAR;
            r_clr_addr    <= '0;
            r_fit_mode    <= fpba_pkg::FIT_MODE_RST;
            r_block_count <= fpba_pkg::BLOCK_COUNT_RST;
            r_rvalid      <= 1'b0;
            r_out_valid   <= 1'b0;
            r_addr        <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == fpba_pkg::ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    fpba_pkg::CFG_FIT_MODE:    r_fit_mode    <= i_cfg_data[1:0];
                    fpba_pkg::CFG_BLOCK_COUNT: r_block_count <= i_cfg_data[4:0];
                    default: begin
                    end
                endcase
            end
            // Advance the read pointer; data for the issued index returns next cycle
            if (is_req) begin
                r_addr <= '0;
            end else if (scan_issue) begin
                r_addr <= r_addr + 1'b1;
            end
            r_rvalid <= scan_issue;
            if (done_fire) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (is_req) begin
            r_size <= SIZE_BITS'(i_in_data.size_value);
            r_used <= used_calc;
        end
        if (scan_issue) begin
            r_ridx <= r_addr[IDX_W-1:0];
        end
        if (done_fire) begin
            r_out_data.granted      <= sel_found;
            r_out_data.chosen_index <= sel_found ? 4'(sel_pick) : 4'd0;
            r_out_data.size_left    <= sel_found ? 32'(wb_val) : 32'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    fpba_mem #(
        .DEPTH (NUM_BLOCKS),
        .WIDTH (SIZE_BITS),
        .AW    (IDX_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (r_addr[IDX_W-1:0]),
        .o_rdata (mem_rdata)
    );

    fpba_sel #(
        .IDX_W     (IDX_W),
        .SIZE_BITS (SIZE_BITS)
    ) u_sel (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (sel_ctl),
        .i_rdata (mem_rdata),
        .i_ridx  (r_ridx),
        .i_size  (r_size),
        .o_found (sel_found),
        .o_pick  (sel_pick),
        .o_best  (sel_best)
    );

endmodule

// ===== hw/rtl/fpba_check.sv =====
// Port-level checker for the fit policy block allocator, bound to the top level.
module fpba_check (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_cfg_valid,
    input logic                            o_cfg_ready,
    input logic [fpba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input logic [fpba_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input logic                            i_in_valid,
    input logic                            o_in_ready,
    input fpba_pkg::t_in_item              i_in_data,
    input logic                            o_out_valid,
    input logic                            i_out_ready,
    input fpba_pkg::t_out_item             o_out_data
);

    // Clearing pass holds input off right after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready during clearing pass");

    // A request occupies the block for at least the following cycle
    a_req_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.op == fpba_pkg::OP_REQ) |=> !o_in_ready)
        else $error("input ready straight after request transfer");

    // A load transfer never raises a result
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.op == fpba_pkg::OP_LOAD && !o_out_valid)
        |=> !o_out_valid)
        else $error("result after load");

    // Hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)))
        else $error("stalled result dropped or changed");

endmodule

bind fit_policy_block_allocator_core fpba_check u_fpba_check (.*);
